// ===== rtl/mcss_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcss_pkg
// Shared types and constants for the mesh clock slew synchroniser.
// ----------------------------------------------------------------------------
package mcss_pkg;

  localparam int unsigned QueueDepth     = 2;
  localparam logic [30:0] MaxAdjustReset = 31'd1000;

  typedef enum logic [2:0] {
    ActNone  = 3'd0,
    ActOlder = 3'd1,
    ActFwd   = 3'd2,
    ActBack  = 3'd3,
    ActJump  = 3'd4
  } act_e;

  // classified beat as held in the queue
  typedef struct packed {
    logic        is_pkt;
    logic [31:0] now;
    logic [31:0] remote;
    logic [31:0] rage;
    logic [31:0] query;
    logic [31:0] new_start;
  } item_t;

endpackage

// ===== rtl/mcss_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcss_front
// Classifies an incoming beat and precomputes the candidate sync start.
// ----------------------------------------------------------------------------
module mcss_front (
  input  logic               req_type_i,
  input  logic [31:0]        now_ms_i,
  input  logic               length_ok_i,
  input  logic [31:0]        remote_synced_ms_i,
  input  logic [31:0]        remote_age_ms_i,
  input  logic [31:0]        query_synced_ms_i,
  output mcss_pkg::item_t    item_o
);

  logic [33:0] age3;

  // exact 3 * age, then floor divide by four
  assign age3 = {2'b00, remote_age_ms_i} + {1'b0, remote_age_ms_i, 1'b0};

  always_comb begin
    item_o.is_pkt    = req_type_i & length_ok_i;
    item_o.now       = now_ms_i;
    item_o.remote    = remote_synced_ms_i;
    item_o.rage      = remote_age_ms_i;
    item_o.query     = query_synced_ms_i;
    item_o.new_start = now_ms_i - age3[33:2];
  end

endmodule

// ===== rtl/mcss_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcss_queue
// Small FIFO decoupling the classifier from the execution pipeline.
// ----------------------------------------------------------------------------
module mcss_queue #(
  parameter int unsigned Depth = mcss_pkg::QueueDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  mcss_pkg::item_t wdata_i,
  output logic            full_o,
  output logic            valid_o,
  input  logic            pop_i,
  output mcss_pkg::item_t rdata_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  mcss_pkg::item_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ===== rtl/mcss_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcss_back
// Applies sync beats to the clock state and reports times in a second stage.
// ----------------------------------------------------------------------------
module mcss_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [30:0]        cfg_wdata_i,
  input  logic               q_valid_i,
  input  mcss_pkg::item_t    q_item_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [31:0]        synced_now_ms_o,
  output logic [31:0]        query_local_ms_o,
  output logic [31:0]        sync_age_ms_o,
  output logic [2:0]         action_o,
  output logic signed [31:0] adjust_ms_o,
  output logic signed [31:0] remote_offset_ms_o
);

  function automatic logic [31:0] to_synced(input logic [31:0] loc, input logic [31:0] off,
                                            input logic [31:0] send, input logic fwd);
    logic [31:0] v;
    logic [31:0] left;
    v    = loc + off;
    left = send - loc;
    if (left != '0 && !left[31]) begin
      v = fwd ? (v - left) : (v + {1'b0, left[31:1]});
    end
    return v;
  endfunction

  function automatic logic [31:0] to_local(input logic [31:0] syn, input logic [31:0] off,
                                           input logic [31:0] send, input logic fwd);
    logic [31:0] v;
    logic [31:0] left;
    v    = syn - off;
    left = send - v;
    if (left != '0 && !left[31]) begin
      v = fwd ? (v + {1'b0, left[31:1]}) : (v - left);
    end
    return v;
  endfunction

  // clock state
  logic [30:0] max_adj_q;
  logic [31:0] off_q, off_d;
  logic [31:0] send_q, send_d;
  logic        sfwd_q, sfwd_d;
  logic [31:0] start_q, start_d;

  // execute stage
  logic        r1_valid_q;
  logic [31:0] r1_now_q, r1_query_q, r1_adj_q, r1_roff_q;
  mcss_pkg::act_e r1_act_q;

  // output register
  logic        out_valid_q;
  logic [31:0] o_sync_q, o_qloc_q, o_age_q, o_adj_q, o_roff_q;
  mcss_pkg::act_e o_act_q;

  logic           out_adv, pop;
  logic [31:0]    cur, roff, bwd, age;
  logic           older;
  mcss_pkg::act_e act_d;
  logic [31:0]    adj_d, roff_d;

  assign out_adv = ~out_valid_q | ~out_stall_i;
  assign pop     = q_valid_i & (~r1_valid_q | out_adv);
  assign q_pop_o = pop;

  always_comb begin
    cur     = to_synced(q_item_i.now, off_q, send_q, sfwd_q);
    roff    = q_item_i.remote - cur;
    bwd     = cur - q_item_i.remote;
    age     = q_item_i.now - start_q;
    older   = q_item_i.rage < age;
    off_d   = off_q;
    send_d  = send_q;
    sfwd_d  = sfwd_q;
    start_d = start_q;
    act_d   = mcss_pkg::ActNone;
    adj_d   = '0;
    roff_d  = '0;
    if (q_item_i.is_pkt) begin
      roff_d = roff;
      if (older) begin
        act_d = mcss_pkg::ActOlder;
      end else begin
        priority if (roff < {1'b0, max_adj_q}) begin
          sfwd_d = 1'b1;
          send_d = q_item_i.now + roff;
          act_d  = mcss_pkg::ActFwd;
          adj_d  = roff;
        end else if (bwd < {1'b0, max_adj_q}) begin
          sfwd_d = 1'b0;
          send_d = q_item_i.now + {bwd[30:0], 1'b0};
          act_d  = mcss_pkg::ActBack;
          adj_d  = roff;
        end else begin
          send_d = q_item_i.now;
          act_d  = mcss_pkg::ActJump;
          adj_d  = roff;
        end
        off_d   = q_item_i.remote - q_item_i.now;
        start_d = q_item_i.new_start;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_adj_q   <= mcss_pkg::MaxAdjustReset;
      off_q       <= '0;
      send_q      <= '0;
      sfwd_q      <= 1'b0;
      start_q     <= '0;
      r1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        max_adj_q <= cfg_wdata_i;
      end
      if (pop) begin
        off_q   <= off_d;
        send_q  <= send_d;
        sfwd_q  <= sfwd_d;
        start_q <= start_d;
      end
      if (pop) begin
        r1_valid_q <= 1'b1;
      end else if (out_adv) begin
        r1_valid_q <= 1'b0;
      end
      if (out_adv) begin
        out_valid_q <= r1_valid_q;
      end
    end
  end

  // state registers always hold the post-update state of the beat in r1
  always_ff @(posedge clk_i) begin
    if (pop) begin
      r1_now_q   <= q_item_i.now;
      r1_query_q <= q_item_i.query;
      r1_act_q   <= act_d;
      r1_adj_q   <= adj_d;
      r1_roff_q  <= roff_d;
    end
    if (out_adv && r1_valid_q) begin
      o_sync_q <= to_synced(r1_now_q, off_q, send_q, sfwd_q);
      o_qloc_q <= to_local(r1_query_q, off_q, send_q, sfwd_q);
      o_age_q  <= r1_now_q - start_q;
      o_act_q  <= r1_act_q;
      o_adj_q  <= r1_adj_q;
      o_roff_q <= r1_roff_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign synced_now_ms_o    = o_sync_q;
  assign query_local_ms_o   = o_qloc_q;
  assign sync_age_ms_o      = o_age_q;
  assign action_o           = o_act_q;
  assign adjust_ms_o        = o_adj_q;
  assign remote_offset_ms_o = o_roff_q;

endmodule

// ===== rtl/mesh_clock_slew_sync.sv =====
`timescale 1ns / 1ps
// An accepted beat passes through the queue, the execute register and the output register.
// Throughput: one beat per cycle while the output is not stalled; the clock state is updated as each beat is popped.
// Input stall rises only when the queue is full behind a stalled output.
// Reset: offset, slew end, slew direction and sync start clear to zero,
// the slew limit returns to 1000, queue and pipeline empty.
// ----------------------------------------------------------------------------
// mesh_clock_slew_sync
// Network-synchronised millisecond clock with slewing and jump correction.
// ----------------------------------------------------------------------------
module mesh_clock_slew_sync #(
  parameter int unsigned QueueDepth = mcss_pkg::QueueDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [30:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               req_type_i,
  input  logic [31:0]        now_ms_i,
  input  logic               length_ok_i,
  input  logic [31:0]        remote_synced_ms_i,
  input  logic [31:0]        remote_age_ms_i,
  input  logic [31:0]        query_synced_ms_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [31:0]        synced_now_ms_o,
  output logic [31:0]        query_local_ms_o,
  output logic [31:0]        sync_age_ms_o,
  output logic [2:0]         action_o,
  output logic signed [31:0] adjust_ms_o,
  output logic signed [31:0] remote_offset_ms_o
);

  mcss_pkg::item_t fe_item, q_item;
  logic            q_full, q_valid, q_pop;

  assign in_stall_o = q_full;

  mcss_front u_front (
    .req_type_i         (req_type_i),
    .now_ms_i           (now_ms_i),
    .length_ok_i        (length_ok_i),
    .remote_synced_ms_i (remote_synced_ms_i),
    .remote_age_ms_i    (remote_age_ms_i),
    .query_synced_ms_i  (query_synced_ms_i),
    .item_o             (fe_item)
  );

  mcss_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_valid_i),
    .wdata_i (fe_item),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .rdata_o (q_item)
  );

  mcss_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .q_valid_i          (q_valid),
    .q_item_i           (q_item),
    .q_pop_o            (q_pop),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .synced_now_ms_o    (synced_now_ms_o),
    .query_local_ms_o   (query_local_ms_o),
    .sync_age_ms_o      (sync_age_ms_o),
    .action_o           (action_o),
    .adjust_ms_o        (adjust_ms_o),
    .remote_offset_ms_o (remote_offset_ms_o)
  );

endmodule

// ===== rtl/mcss_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcss_checker
// Port-level checks for the mesh clock slew synchroniser.
// ----------------------------------------------------------------------------
module mcss_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [31:0]        synced_now_ms_o,
  input logic [2:0]         action_o,
  input logic signed [31:0] adjust_ms_o,
  input logic signed [31:0] remote_offset_ms_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(synced_now_ms_o)
      && $stable(action_o) && $stable(remote_offset_ms_o))
    else $error("stalled output beat changed");

  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && action_o == mcss_pkg::ActNone |-> adjust_ms_o == 0
      && remote_offset_ms_o == 0)
    else $error("query beat carries adjustment");

  a_older_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && action_o == mcss_pkg::ActOlder |-> adjust_ms_o == 0)
    else $error("ignored beat carries adjustment");

  a_adj_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (action_o == mcss_pkg::ActFwd || action_o == mcss_pkg::ActBack
      || action_o == mcss_pkg::ActJump) |-> adjust_ms_o == remote_offset_ms_o)
    else $error("adjustment differs from remote offset");

endmodule

bind mesh_clock_slew_sync mcss_checker u_mcss_checker (.*);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for mesh_clock_slew_sync: a local clock model predicts
// the synced time, query conversion, sync age and adjustment of every beat.
// Directed cases cover the field extremes, ignored packets, slew limits and
// jumps. Random traffic follows under four idle/stall mixes and several
// slew limit settings.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned CycleLimit = 400000;

  typedef struct {
    logic [31:0]      synced_now;
    logic [31:0]      query_local;
    logic [31:0]      sync_age;
    mcss_pkg::act_e   action;
    logic [31:0]      adjust;
    logic [31:0]      remote_offset;
  } reading_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [30:0]        cfg_wdata_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic               req_type_i = 1'b0;
  logic [31:0]        now_ms_i = '0;
  logic               length_ok_i = 1'b0;
  logic [31:0]        remote_synced_ms_i = '0;
  logic [31:0]        remote_age_ms_i = '0;
  logic [31:0]        query_synced_ms_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [31:0]        synced_now_ms_o;
  logic [31:0]        query_local_ms_o;
  logic [31:0]        sync_age_ms_o;
  logic [2:0]         action_o;
  logic signed [31:0] adjust_ms_o;
  logic signed [31:0] remote_offset_ms_o;

  // clock model state
  logic [31:0] pred_offset = '0;
  logic [31:0] pred_slew_end = '0;
  logic        pred_slew_fwd = 1'b0;
  logic [31:0] pred_sync_start = '0;
  logic [30:0] pred_max_adjust = mcss_pkg::MaxAdjustReset;

  reading_t    due_readings[$];
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned src_idle_pct = 0;
  int unsigned snk_stall_pct = 0;
  logic [31:0] wall_ms = '0;

  mesh_clock_slew_sync DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .req_type_i         (req_type_i),
    .now_ms_i           (now_ms_i),
    .length_ok_i        (length_ok_i),
    .remote_synced_ms_i (remote_synced_ms_i),
    .remote_age_ms_i    (remote_age_ms_i),
    .query_synced_ms_i  (query_synced_ms_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .synced_now_ms_o    (synced_now_ms_o),
    .query_local_ms_o   (query_local_ms_o),
    .sync_age_ms_o      (sync_age_ms_o),
    .action_o           (action_o),
    .adjust_ms_o        (adjust_ms_o),
    .remote_offset_ms_o (remote_offset_ms_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("mesh_clock_slew_sync test failed");
      $finish;
    end
  end

  // wraparound order: a lies 1 .. 2^31-1 after b
  function automatic logic later_than(logic [31:0] a, logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return (d != 32'd0) && !d[31];
  endfunction

  function automatic logic [31:0] local_to_synced(logic [31:0] loc);
    logic [31:0] v;
    logic [31:0] left;
    v = loc + pred_offset;
    if (later_than(pred_slew_end, loc)) begin
      left = pred_slew_end - loc;
      if (pred_slew_fwd) v = v - left;
      else v = v + (left >> 1);
    end
    return v;
  endfunction

  function automatic logic [31:0] synced_to_local(logic [31:0] syn);
    logic [31:0] v;
    logic [31:0] left;
    v = syn - pred_offset;
    if (later_than(pred_slew_end, v)) begin
      left = pred_slew_end - v;
      if (pred_slew_fwd) v = v + (left >> 1);
      else v = v - left;
    end
    return v;
  endfunction

  function automatic reading_t predict_reading(logic req, logic [31:0] now_v, logic len_ok,
                                               logic [31:0] remote, logic [31:0] rage,
                                               logic [31:0] query);
    reading_t    r;
    logic [31:0] cur;
    logic [31:0] old_off;
    logic [31:0] new_off;
    logic [31:0] fwd;
    logic [31:0] bwd;
    logic [33:0] triple;
    r.action = mcss_pkg::ActNone;
    r.adjust = '0;
    r.remote_offset = '0;
    if (req && len_ok) begin
      cur = local_to_synced(now_v);
      r.remote_offset = remote - cur;
      if (rage < now_v - pred_sync_start) begin
        r.action = mcss_pkg::ActOlder;
      end else begin
        old_off = cur - now_v;
        new_off = remote - now_v;
        fwd = new_off - old_off;
        bwd = old_off - new_off;
        if (fwd < {1'b0, pred_max_adjust}) begin
          pred_slew_fwd = 1'b1;
          pred_slew_end = now_v + fwd;
          r.action = mcss_pkg::ActFwd;
          r.adjust = fwd;
        end else if (bwd < {1'b0, pred_max_adjust}) begin
          pred_slew_fwd = 1'b0;
          pred_slew_end = now_v + (bwd << 1);
          r.action = mcss_pkg::ActBack;
          r.adjust = 32'd0 - bwd;
        end else begin
          pred_slew_end = now_v;
          r.action = mcss_pkg::ActJump;
          r.adjust = fwd;
        end
        pred_offset = new_off;
        triple = {2'b00, rage} * 34'd3;
        pred_sync_start = now_v - triple[33:2];
      end
    end
    r.synced_now = local_to_synced(now_v);
    r.query_local = synced_to_local(query);
    r.sync_age = now_v - pred_sync_start;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %s: expected %h, got %h", what, want, got);
  endtask

  always @(posedge clk_i) begin : check_readings
    reading_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (due_readings.size() == 0) begin
        report_mismatch("result with none awaited", '0, synced_now_ms_o);
      end else begin
        want = due_readings.pop_front();
        if (synced_now_ms_o !== want.synced_now)
          report_mismatch("synced_now_ms", want.synced_now, synced_now_ms_o);
        if (query_local_ms_o !== want.query_local)
          report_mismatch("query_local_ms", want.query_local, query_local_ms_o);
        if (sync_age_ms_o !== want.sync_age)
          report_mismatch("sync_age_ms", want.sync_age, sync_age_ms_o);
        if (action_o !== want.action)
          report_mismatch("action", 32'(want.action), 32'(action_o));
        if (adjust_ms_o !== want.adjust)
          report_mismatch("adjust_ms", want.adjust, adjust_ms_o);
        if (remote_offset_ms_o !== want.remote_offset)
          report_mismatch("remote_offset_ms", want.remote_offset, remote_offset_ms_o);
      end
    end
    out_stall_i <= ($urandom_range(99) < snk_stall_pct);
  end

  // valid is left high after acceptance; the next call, while idling, or the caller lowers it
  task automatic send_beat(logic req, logic [31:0] now_v, logic len_ok,
                           logic [31:0] remote, logic [31:0] rage, logic [31:0] query);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i         <= 1'b1;
    req_type_i         <= req;
    now_ms_i           <= now_v;
    length_ok_i        <= len_ok;
    remote_synced_ms_i <= remote;
    remote_age_ms_i    <= rage;
    query_synced_ms_i  <= query;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    due_readings.push_back(predict_reading(req, now_v, len_ok, remote, rage, query));
  endtask

  // accepted packet whose forward error and age margin are chosen directly
  task automatic sync_packet(logic [31:0] now_v, logic [31:0] err, logic [31:0] age_margin);
    send_beat(1'b1, now_v, 1'b1, local_to_synced(now_v) + err,
              now_v - pred_sync_start + age_margin, local_to_synced(now_v) + 32'd7);
  endtask

  task automatic write_max_adjust(logic [30:0] value);
    in_valid_i <= 1'b0;
    while (due_readings.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    pred_max_adjust = value;
  endtask

  task automatic test_query_extremes();
    send_beat(1'b0, 32'd0, 1'b0, 32'd0, 32'd0, 32'd0);
    send_beat(1'b0, '1, 1'b1, '1, '1, '1);
  endtask

  task automatic test_packet_handling();
    send_beat(1'b1, 32'd100, 1'b0, 32'h1234_5678, 32'hFFFF_FFFF, 32'd90);
    send_beat(1'b1, 32'd100, 1'b1, 32'd555, 32'd0, 32'd50);
    send_beat(1'b1, 32'd200, 1'b1, local_to_synced(32'd200) + 32'd500, '1, 32'd300);
    send_beat(1'b0, 32'd300, 1'b0, $urandom(), $urandom(), local_to_synced(32'd300) + 32'd100);
    sync_packet(32'd2000, 32'd0 - 32'd300, 32'd0);
    sync_packet(32'd5000, 32'h1234_5678, 32'd10);
    sync_packet(32'd5000, 32'd0, 32'd0);
    send_beat(1'b1, 32'hFFFF_FFF0, 1'b0, '1, 32'd0, '1);
    sync_packet(32'hFFFF_FF00, 32'd900, 32'd1);
    send_beat(1'b0, 32'h0000_0100, 1'b0, '0, '0, local_to_synced(32'h0000_0100));
  endtask

  task automatic test_adjust_limits();
    wall_ms = 32'h0001_0000;
    sync_packet(wall_ms, 32'd999, 32'd0);
    sync_packet(wall_ms + 32'd1000, 32'd1000, 32'd0);
    sync_packet(wall_ms + 32'd2000, 32'd0 - 32'd999, 32'd0);
    sync_packet(wall_ms + 32'd3000, 32'd0 - 32'd1000, 32'd0);
    write_max_adjust(31'd1);
    sync_packet(wall_ms + 32'd4000, 32'd0, 32'd0);
    sync_packet(wall_ms + 32'd5000, 32'd1, 32'd0);
    write_max_adjust(31'h7FFF_FFFF);
    sync_packet(wall_ms + 32'd6000, 32'h7FFF_FFFE, 32'd0);
    sync_packet(wall_ms + 32'd7000, 32'h7FFF_FFFF, 32'd0);
    sync_packet(wall_ms + 32'd8000, 32'h8000_0000, 32'd0);
    sync_packet(wall_ms + 32'd9000, 32'd0 - 32'h7FFF_FFFE, 32'd0);
    sync_packet(wall_ms + 32'd10000, 32'd0 - 32'h7FFF_FFFF, 32'd0);
    wall_ms = wall_ms + 32'd10000;
  endtask

  task automatic random_beat();
    logic [31:0] now_v;
    logic [31:0] cur;
    logic [31:0] age;
    logic [31:0] span;
    logic [31:0] remote;
    logic [31:0] rage;
    logic [31:0] query;
    int unsigned kind;
    int unsigned pick;
    kind = $urandom_range(99);
    if ($urandom_range(19) == 0) wall_ms = $urandom();
    else wall_ms = wall_ms + $urandom_range(3000);
    now_v = wall_ms;
    cur = local_to_synced(now_v);
    age = now_v - pred_sync_start;
    span = {1'b0, pred_max_adjust};
    case ($urandom_range(4))
      0: remote = cur + $urandom_range(span);
      1: remote = cur - $urandom_range(span);
      2: remote = cur + span - 32'd1 + $urandom_range(2);
      3: remote = cur - span + 32'd1 - $urandom_range(2);
      default: remote = $urandom();
    endcase
    pick = $urandom_range(9);
    if (pick == 0) rage = $urandom();
    else if (pick == 1) rage = age - 32'd1 - $urandom_range(100);
    else rage = age + $urandom_range(4000);
    if ($urandom_range(3) == 0) query = $urandom();
    else query = cur + $urandom_range(6000) - 32'd3000;
    send_beat(kind >= 20, now_v, kind >= 32, remote, rage, query);
  endtask

  task automatic test_random_traffic();
    logic [30:0] settings [0:7];
    settings[0] = 31'd1000;
    settings[1] = 31'd1;
    settings[2] = 31'h7FFF_FFFF;
    settings[3] = 31'd37;
    settings[4] = 31'd250000;
    settings[5] = mcss_pkg::MaxAdjustReset;
    settings[6] = 31'd5;
    settings[7] = 31'h4000_0000;
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 74; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 74; end
        default: begin src_idle_pct = 23; snk_stall_pct = 23; end
      endcase
      for (int s = 0; s < 2; s++) begin
        write_max_adjust(settings[2 * p + s]);
        repeat (144) random_beat();
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_query_extremes();
    test_packet_handling();
    test_adjust_limits();
    test_random_traffic();
    in_valid_i <= 1'b0;
    while (due_readings.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("mesh_clock_slew_sync test passed");
    end else begin
      $display("mesh_clock_slew_sync test failed");
    end
    $finish;
  end

endmodule
